FILE: rtl/mie_pkg.sv
// Package for the modular inverse block: constants, controller states, command and status types.
package mie_pkg;

  localparam int unsigned ValueBitsDefault = 31;
  localparam int unsigned ModulusWidth = 31;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned InverseWidth = 31;
  localparam logic [ModulusWidth-1:0] ModulusReset = 31'd1000000007;

  typedef enum logic [2:0] {
    StIdle,
    StRedGrow,
    StRedShrink,
    StRedFix,
    StEuCheck,
    StEuGrow,
    StEuShrink,
    StFinish
  } state_e;

  typedef struct packed {
    logic load_zero;
    logic load_red;
    logic grow;
    logic shrink;
    logic mode_eu;
    logic eu_init;
    logic step_init;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic grow_more;
    logic cnt_zero;
    logic x_zero;
    logic m_zero;
  } status_t;

endpackage

FILE: rtl/mie_ctrl.sv
// Controller for the modular inverse block: sequences reduction, Euclid steps and result transfer.
module mie_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mie_pkg::status_t status_i,
  output mie_pkg::cmd_t    cmd_o
);

  mie_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mie_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = status_i.m_zero ? mie_pkg::StEuCheck : mie_pkg::StRedGrow;
        end
      end
      mie_pkg::StRedGrow: begin
        if (!status_i.grow_more) begin
          state_d = mie_pkg::StRedShrink;
        end
      end
      mie_pkg::StRedShrink: begin
        if (status_i.cnt_zero) begin
          state_d = mie_pkg::StRedFix;
        end
      end
      mie_pkg::StRedFix: state_d = mie_pkg::StEuCheck;
      mie_pkg::StEuCheck: begin
        state_d = status_i.x_zero ? mie_pkg::StFinish : mie_pkg::StEuGrow;
      end
      mie_pkg::StEuGrow: begin
        if (!status_i.grow_more) begin
          state_d = mie_pkg::StEuShrink;
        end
      end
      mie_pkg::StEuShrink: begin
        if (status_i.cnt_zero) begin
          state_d = mie_pkg::StEuCheck;
        end
      end
      mie_pkg::StFinish: begin
        if (out_free) begin
          state_d = mie_pkg::StIdle;
        end
      end
      default: state_d = mie_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      mie_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_zero = status_i.m_zero;
          cmd_o.load_red  = !status_i.m_zero;
        end
      end
      mie_pkg::StRedGrow: cmd_o.grow = status_i.grow_more;
      mie_pkg::StRedShrink: cmd_o.shrink = 1'b1;
      mie_pkg::StRedFix: cmd_o.eu_init = 1'b1;
      mie_pkg::StEuCheck: cmd_o.step_init = !status_i.x_zero;
      mie_pkg::StEuGrow: cmd_o.grow = status_i.grow_more;
      mie_pkg::StEuShrink: begin
        cmd_o.shrink  = 1'b1;
        cmd_o.mode_eu = 1'b1;
      end
      mie_pkg::StFinish: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mie_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/mie_datapath.sv
// Datapath for the modular inverse block: modulus register, shift-subtract divider, coefficients.
module mie_datapath #(
  parameter int unsigned VALUE_BITS = mie_pkg::ValueBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [mie_pkg::ModulusWidth-1:0]    cfg_modulus_i,
  input  logic signed [mie_pkg::ValueWidth-1:0] value_i,
  input  mie_pkg::cmd_t                       cmd_i,
  output mie_pkg::status_t                    status_o,
  output logic [mie_pkg::InverseWidth-1:0]    inverse_o,
  output logic                                no_inverse_o
);

  localparam int unsigned DW = ((VALUE_BITS > mie_pkg::ValueWidth) ? VALUE_BITS
                                                                  : mie_pkg::ValueWidth) + 1;
  localparam int unsigned CW = VALUE_BITS + 2;
  localparam int unsigned NW = $clog2(DW);

  logic [VALUE_BITS-1:0]   m_q;
  logic [DW-1:0]           y_q, y_d, d_q, d_d;
  logic [VALUE_BITS-1:0]   x_q, x_d;
  logic signed [CW-1:0]    cx_q, cx_d, cy_q, cy_d, cd_q, cd_d;
  logic [NW-1:0]           cnt_q, cnt_d;
  logic                    neg_q, neg_d;
  logic [mie_pkg::InverseWidth-1:0] inverse_q, inverse_d;
  logic                    no_inv_q, no_inv_d;

  logic [DW-1:0]           d_dbl, y_sub, y_cur;
  logic signed [CW-1:0]    cy_cur, res_fix;
  logic [mie_pkg::ValueWidth-1:0] mag;
  logic                    ge, flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= VALUE_BITS'(mie_pkg::ModulusReset);
    end else if (cfg_valid_i) begin
      m_q <= VALUE_BITS'(cfg_modulus_i);
    end
  end

  assign d_dbl  = {d_q[DW-2:0], 1'b0};
  assign ge     = y_q >= d_q;
  assign y_sub  = y_q - d_q;
  assign y_cur  = ge ? y_sub : y_q;
  assign cy_cur = (ge && cmd_i.mode_eu) ? (cy_q - cd_q) : cy_q;
  assign mag    = value_i[mie_pkg::ValueWidth-1] ? (~value_i + 1'b1) : value_i;

  assign flag    = y_q != DW'(1);
  assign res_fix = cy_q[CW-1] ? (cy_q + $signed(CW'(m_q))) : cy_q;

  assign status_o.grow_more = d_dbl <= y_q;
  assign status_o.cnt_zero  = cnt_q == '0;
  assign status_o.x_zero    = x_q == '0;
  assign status_o.m_zero    = m_q == '0;

  always_comb begin
    y_d       = y_q;
    d_d       = d_q;
    x_d       = x_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    cd_d      = cd_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    inverse_d = inverse_q;
    no_inv_d  = no_inv_q;
    if (cmd_i.load_zero) begin
      x_d  = '0;
      y_d  = '0;
      cy_d = '0;
    end
    if (cmd_i.load_red) begin
      y_d   = DW'(mag);
      d_d   = DW'(m_q);
      cnt_d = '0;
      neg_d = value_i[mie_pkg::ValueWidth-1];
    end
    if (cmd_i.grow) begin
      d_d   = d_dbl;
      cd_d  = cd_q <<< 1;
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.shrink) begin
      if (cnt_q != '0) begin
        y_d   = y_cur;
        cy_d  = cy_cur;
        d_d   = d_q >> 1;
        cd_d  = cd_q >>> 1;
        cnt_d = cnt_q - 1'b1;
      end else if (cmd_i.mode_eu) begin
        x_d  = y_cur[VALUE_BITS-1:0];
        y_d  = d_q;
        cx_d = cy_cur;
        cy_d = cx_q;
      end else begin
        y_d = y_cur;
      end
    end
    if (cmd_i.eu_init) begin
      x_d  = (neg_q && (y_q != '0)) ? (m_q - y_q[VALUE_BITS-1:0]) : y_q[VALUE_BITS-1:0];
      y_d  = DW'(m_q);
      cx_d = CW'(1);
      cy_d = '0;
    end
    if (cmd_i.step_init) begin
      d_d   = DW'(x_q);
      cd_d  = cx_q;
      cnt_d = '0;
    end
    if (cmd_i.out_load) begin
      no_inv_d  = flag;
      inverse_d = flag ? '0 : mie_pkg::InverseWidth'(res_fix[VALUE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    y_q       <= y_d;
    d_q       <= d_d;
    x_q       <= x_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    cd_q      <= cd_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    inverse_q <= inverse_d;
    no_inv_q  <= no_inv_d;
  end

  assign inverse_o    = inverse_q;
  assign no_inverse_o = no_inv_q;

endmodule

FILE: rtl/modular_inverse_ext_euclid.sv
// Operation: data dependent in length; the input value is first reduced modulo the modulus by the
//   shift-subtract divider, then each Euclid step runs one division on it, and the result is
//   registered once the output is free; a zero modulus skips the reduction and the steps.
// Throughput: one item at a time; the next transfer is taken in the idle cycle after the
//   result is registered, and a result held by the receiver stalls the input.
// Reset: asynchronous, active low; controller returns to idle, modulus reloads 1000000007.
module modular_inverse_ext_euclid #(
  parameter int unsigned VALUE_BITS = mie_pkg::ValueBitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mie_pkg::ModulusWidth-1:0]      cfg_modulus_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [mie_pkg::ValueWidth-1:0] value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mie_pkg::InverseWidth-1:0]      inverse_o,
  output logic                                  no_inverse_o
);

  mie_pkg::cmd_t    cmd;
  mie_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  mie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mie_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_modulus_i (cfg_modulus_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .inverse_o     (inverse_o),
    .no_inverse_o  (no_inverse_o)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for modular_inverse_ext_euclid: directed table, random phases, predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mie_pkg::InverseWidth-1:0] inverse;
    logic                             no_inverse;
  } inv_result_t;

  typedef enum logic {
    RowValue,
    RowModulus
  } row_kind_e;

  typedef struct packed {
    row_kind_e                        kind;
    logic [mie_pkg::ValueWidth-1:0]   data;
    logic                             typed;
    logic [mie_pkg::InverseWidth-1:0] inverse;
    logic                             no_inverse;
  } vec_row_t;

  localparam int unsigned NumPhases = 15;
  localparam int unsigned ItemsPerPhase = 96;
  localparam int unsigned IdlePct = 14;
  localparam int unsigned CalmFirst = 700;
  localparam int unsigned CalmLast = 900;
  localparam int unsigned HoldAfter = 300;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned TailCycles = 300;
  localparam int unsigned MaxReports = 10;

  // typed expectations only where they follow directly from the modulus
  localparam vec_row_t DirectedRows [26] = '{
    '{RowValue,   32'd0,          1'b1, 31'd0,          1'b1},
    '{RowValue,   32'd1,          1'b1, 31'd1,          1'b0},
    '{RowValue,   32'hFFFF_FFFF,  1'b1, 31'd1000000006, 1'b0},
    '{RowValue,   32'h7FFF_FFFF,  1'b0, 31'd0,          1'b0},
    '{RowValue,   32'h8000_0000,  1'b0, 31'd0,          1'b0},
    '{RowValue,   32'd1000000007, 1'b1, 31'd0,          1'b1},
    '{RowValue,   32'd2,          1'b1, 31'd500000004,  1'b0},
    '{RowModulus, 32'd1,          1'b0, 31'd0,          1'b0},
    '{RowValue,   32'h8000_0000,  1'b1, 31'd0,          1'b0},
    '{RowValue,   32'h7FFF_FFFF,  1'b1, 31'd0,          1'b0},
    '{RowValue,   32'd0,          1'b1, 31'd0,          1'b0},
    '{RowModulus, 32'h7FFF_FFFF,  1'b0, 31'd0,          1'b0},
    '{RowValue,   32'h7FFF_FFFF,  1'b1, 31'd0,          1'b1},
    '{RowValue,   32'hFFFF_FFFF,  1'b1, 31'h7FFF_FFFE,  1'b0},
    '{RowValue,   32'h8000_0000,  1'b1, 31'h7FFF_FFFE,  1'b0},
    '{RowValue,   32'h1234_5678,  1'b0, 31'd0,          1'b0},
    '{RowModulus, 32'd12,         1'b0, 31'd0,          1'b0},
    '{RowValue,   32'd6,          1'b1, 31'd0,          1'b1},
    '{RowValue,   32'd5,          1'b1, 31'd5,          1'b0},
    '{RowValue,   -32'sd7,        1'b0, 31'd0,          1'b0},
    '{RowValue,   32'h8000_0000,  1'b0, 31'd0,          1'b0},
    '{RowModulus, 32'd0,          1'b0, 31'd0,          1'b0},
    '{RowValue,   32'd5,          1'b1, 31'd0,          1'b1},
    '{RowValue,   32'd0,          1'b1, 31'd0,          1'b1},
    '{RowModulus, 32'd2,          1'b0, 31'd0,          1'b0},
    '{RowValue,   -32'sd3,        1'b1, 31'd1,          1'b0}
  };

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [mie_pkg::ModulusWidth-1:0]      cfg_modulus = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [mie_pkg::ValueWidth-1:0] value = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [mie_pkg::InverseWidth-1:0]      inverse;
  logic                                  no_inverse;

  logic [mie_pkg::ModulusWidth-1:0] cur_modulus = mie_pkg::ModulusReset;
  inv_result_t             pending_inverses[$];
  int unsigned             items_sent = 0;
  int unsigned             results_checked = 0;
  int unsigned             modulus_writes = 0;
  int unsigned             flagged_results = 0;
  int unsigned             mismatches = 0;
  int unsigned             hold_left = 0;
  bit                      hold_done = 1'b0;

  modular_inverse_ext_euclid dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_modulus_i (cfg_modulus),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .inverse_o     (inverse),
    .no_inverse_o  (no_inverse)
  );

  always #1 clk = ~clk;

  function automatic inv_result_t predict_inverse(
      input logic [mie_pkg::ValueWidth-1:0] raw,
      input logic [mie_pkg::ModulusWidth-1:0] mod_reg);
    longint unsigned m, r, x, y, cx, cy, q, rem, ncy;
    inv_result_t res;
    m = 64'(mod_reg);
    res.inverse = '0;
    res.no_inverse = 1'b1;
    if (m != 0) begin
      if (raw[mie_pkg::ValueWidth-1]) begin
        r = ((64'd1 << mie_pkg::ValueWidth) - 64'(raw)) % m;
        if (r != 0) r = m - r;
      end else begin
        r = 64'(raw) % m;
      end
      x = r;
      y = m;
      cx = 1;
      cy = 0;
      while (x != 0) begin
        q = y / x;
        rem = y % x;
        ncy = cy - q * cx;
        y = x;
        x = rem;
        cy = cx;
        cx = ncy;
      end
      if (y == 1) begin
        if ((cy >> 63) != 0) cy = m + cy;
        res.inverse = cy[mie_pkg::InverseWidth-1:0];
        res.no_inverse = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [mie_pkg::ModulusWidth-1:0] pick_modulus();
    case ($urandom_range(9))
      0, 1: return mie_pkg::ModulusWidth'($urandom_range(40, 1));
      2: return 31'h7FFF_FFFF;
      3: return 31'd998244353;
      4: return 31'(1) << $urandom_range(30, 1);
      5: return mie_pkg::ModulusWidth'($urandom_range(65535, 2));
      default: return mie_pkg::ModulusWidth'($urandom());
    endcase
  endfunction

  function automatic logic [mie_pkg::ValueWidth-1:0] pick_value(
      input logic [mie_pkg::ModulusWidth-1:0] m);
    logic [mie_pkg::ValueWidth-1:0] v;
    case ($urandom_range(9))
      0: v = mie_pkg::ValueWidth'($urandom_range(40)) - 32'd20;
      1: v = mie_pkg::ValueWidth'(m) * mie_pkg::ValueWidth'($urandom_range(3));
      2: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'd0;
          default: v = 32'd1;
        endcase
      end
      3: v = mie_pkg::ValueWidth'(m) + mie_pkg::ValueWidth'($urandom_range(2)) - 32'd1;
      default: v = $urandom();
    endcase
    if ($urandom_range(3) == 0) v = -v;
    return v;
  endfunction

  // one input transfer; called and returns at a falling edge
  task automatic send_value(input logic [mie_pkg::ValueWidth-1:0] v, input logic typed,
                            input inv_result_t typed_exp);
    bit calm;
    calm = (items_sent >= CalmFirst) && (items_sent < CalmLast);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!in_ready);
    pending_inverses.push_back(typed ? typed_exp : predict_inverse(v, cur_modulus));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_modulus(input logic [mie_pkg::ModulusWidth-1:0] m);
    in_valid <= 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_modulus <= m;
    do @(posedge clk); while (!cfg_ready);
    cur_modulus = m;
    modulus_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_checked >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ((results_checked >= CalmFirst) && (results_checked < CalmLast)) ||
                   ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    inv_result_t exp;
    if (out_valid && out_ready) begin
      if (pending_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("ERROR: unexpected result inverse=%0d no_inverse=%0b", inverse, no_inverse);
      end else begin
        exp = pending_inverses.pop_front();
        if (exp.inverse !== inverse || exp.no_inverse !== no_inverse) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("ERROR: result %0d: inverse exp %0d got %0d, no_inverse exp %0b got %0b",
                     results_checked, exp.inverse, inverse, exp.no_inverse, no_inverse);
        end
        if (no_inverse) flagged_results++;
      end
      results_checked++;
    end
  end

  initial begin
    inv_result_t typed_exp;
    logic [mie_pkg::ModulusWidth-1:0] m;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowModulus) begin
        write_modulus(DirectedRows[i].data[mie_pkg::ModulusWidth-1:0]);
      end else begin
        typed_exp.inverse = DirectedRows[i].inverse;
        typed_exp.no_inverse = DirectedRows[i].no_inverse;
        send_value(DirectedRows[i].data, DirectedRows[i].typed, typed_exp);
      end
    end
    typed_exp = '0;
    for (int p = 0; p < NumPhases; p++) begin
      m = (p == 0) ? 31'h7FFF_FFFF : pick_modulus();
      write_modulus(m);
      for (int n = 0; n < ItemsPerPhase; n++) send_value(pick_value(m), 1'b0, typed_exp);
    end
    in_valid <= 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk);
    repeat (TailCycles) @(posedge clk);
    $display("Run covered %0d values over %0d modulus writes; %0d results compared, %0d flagged.",
             items_sent, modulus_writes, results_checked, flagged_results);
    if (mismatches == 0 && pending_inverses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d results outstanding", pending_inverses.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mie_pkg.sv
rtl/mie_ctrl.sv
rtl/mie_datapath.sv
rtl/modular_inverse_ext_euclid.sv
dv/tb.sv
